// File: src/tte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types, constants and helpers of the text terminal escape engine.
// ----------------------------------------------------------------------------
package tte_pkg;

   localparam int COLUMNS = 40;
   localparam int ROWS    = 29;
   localparam int CELLS   = ROWS * COLUMNS;
   localparam int COL_W   = 6;
   localparam int ROW_W   = 5;
   localparam int ADDR_W  = $clog2(CELLS);

   // character codes
   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_ESC   = 8'd27;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_DEL   = 8'd127;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;
   localparam logic [7:0] CH_SEMI  = 8'd59;
   localparam logic [7:0] CH_QUEST = 8'd63;
   localparam logic [7:0] CH_UA    = 8'd65;
   localparam logic [7:0] CH_UB    = 8'd66;
   localparam logic [7:0] CH_UC    = 8'd67;
   localparam logic [7:0] CH_UD    = 8'd68;
   localparam logic [7:0] CH_UH    = 8'd72;
   localparam logic [7:0] CH_UJ    = 8'd74;
   localparam logic [7:0] CH_UY    = 8'd89;
   localparam logic [7:0] CH_LBR   = 8'd91;
   localparam logic [7:0] CH_LM    = 8'd109;
   localparam logic [7:0] Y_BIAS   = 8'd31;
   localparam logic [7:0] BG_LOW   = 8'd40;
   localparam logic [7:0] BG_HIGH  = 8'd48;

   typedef enum logic [2:0] {
      PS_IDLE = 3'd0,
      PS_ESC  = 3'd1,
      PS_ARG1 = 3'd2,
      PS_ARG2 = 3'd3,
      PS_YROW = 3'd4,
      PS_YCOL = 3'd5,
      PS_PRIV = 3'd6
   } parse_type;

   typedef enum logic [2:0] {
      S_INIT  = 3'd0,
      S_IDLE  = 3'd1,
      S_FEED  = 3'd2,
      S_FILL  = 3'd3,
      S_CLEAR = 3'd4,
      S_READ  = 3'd5,
      S_RESP  = 3'd6
   } ctrl_state_type;

   typedef struct packed {
      logic latch;
      logic feed_en;
      logic feed_cr;
      logic sweep_fill;
      logic sweep_clear;
      logic rsp_valid;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_fill;
      logic need_clear;
      logic second_pass;
      logic sweep_done;
      logic is_read;
   } dp_status_type;

   // reduce a value below 16*ROWS modulo ROWS
   function automatic logic [ROW_W-1:0] mod_rows(input logic [8:0] v);
      logic [8:0] t;
      t = v;
      if (t >= 9'(8 * ROWS)) t = t - 9'(8 * ROWS);
      if (t >= 9'(4 * ROWS)) t = t - 9'(4 * ROWS);
      if (t >= 9'(2 * ROWS)) t = t - 9'(2 * ROWS);
      if (t >= 9'(ROWS))     t = t - 9'(ROWS);
      return t[ROW_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
   endfunction

   function automatic logic [ROW_W-1:0] row_next(input logic [ROW_W-1:0] r);
      return (r == ROW_W'(ROWS - 1)) ? '0 : r + 1'b1;
   endfunction

   function automatic logic [ROW_W-1:0] row_prev(input logic [ROW_W-1:0] r);
      return (r == '0) ? ROW_W'(ROWS - 1) : r - 1'b1;
   endfunction

endpackage

// File: src/tte_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_ctrl
// Sequencer: clearing pass, byte feed passes, row fill, screen clear, cell read, response.
// ----------------------------------------------------------------------------
module tte_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tte_pkg::dp_status_type status,
   output tte_pkg::ctrl_cmd_type  cmd
);
   import tte_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           pass_ff, pass_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      unique case (state_ff)
         S_INIT: begin
            if (status.sweep_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               pass_in  = 1'b0;
               state_in = status.is_read ? S_READ : S_FEED;
            end
         end
         S_FEED: begin
            if (status.need_clear) state_in = S_CLEAR;
            else if (status.need_fill) state_in = S_FILL;
            else if (!pass_ff && status.second_pass) pass_in = 1'b1;
            else state_in = S_RESP;
         end
         S_FILL, S_CLEAR: begin
            if (status.sweep_done) begin
               if (!pass_ff && status.second_pass) begin
                  pass_in  = 1'b1;
                  state_in = S_FEED;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_READ: state_in = S_RESP;
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         S_INIT:  cmd.sweep_clear = 1'b1;
         S_IDLE: begin
            busy      = 1'b0;
            cmd.latch = start;
         end
         S_FEED: begin
            cmd.feed_en = 1'b1;
            cmd.feed_cr = pass_ff;
         end
         S_FILL:  cmd.sweep_fill  = 1'b1;
         S_CLEAR: cmd.sweep_clear = 1'b1;
         S_READ:  ;
         S_RESP:  cmd.rsp_valid   = 1'b1;
         default: ;
      endcase
   end

endmodule

// File: src/tte_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_datapath
// Escape parser, cursor and scroll registers, and the circular screen store.
// ----------------------------------------------------------------------------
module tte_datapath (
   input  logic                          clock,
   input  tte_pkg::ctrl_cmd_type          cmd,
   output tte_pkg::dp_status_type         status,
   input  logic                          cfg_we,
   input  logic                          cfg_nl,
   input  logic                          reset,
   input  logic                          in_kind,
   input  logic [7:0]                    in_char,
   input  logic [4:0]                    in_row,
   input  logic [5:0]                    in_col,
   output logic [6:0]                    cell_value,
   output logic [tte_pkg::ROW_W-1:0]      cursor_row,
   output logic [tte_pkg::COL_W-1:0]      cursor_col,
   output logic [tte_pkg::ROW_W-1:0]      top_row,
   output logic                          background
);
   import tte_pkg::*;

   logic [6:0] mem [CELLS];
   logic [6:0] mem_q_ff;

   logic             kind_ff;
   logic [7:0]       char_ff;
   logic [4:0]       rrow_ff;
   logic [5:0]       rcol_ff;
   logic             nl_ff;
   parse_type        ps_ff, ps_in;
   logic [7:0]       n1_ff, n1_in, n2_ff, n2_in;
   logic [ROW_W-1:0] crow_ff, crow_in, top_ff, top_in, fill_row_ff, fill_row_in;
   logic [COL_W-1:0] ccol_ff, ccol_in;
   logic             bg_ff, bg_in;
   logic [ADDR_W-1:0] cnt_ff;

   // feed decode
   logic [7:0]       c;
   logic [6:0]       c7;
   logic             digit, lf, mv, fin, fin_h, fwr, fill, clr;
   logic [COL_W-1:0] wcol;
   logic [6:0]       wdata;
   logic [7:0]       fr, fk, mc;
   logic [ROW_W-1:0] lrow;

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ps_ff   <= PS_IDLE;
         n1_ff   <= '0;
         n2_ff   <= '0;
         crow_ff <= '0;
         ccol_ff <= '0;
         top_ff  <= '0;
         bg_ff   <= 1'b0;
         nl_ff   <= 1'b1;
         cnt_ff  <= '0;
      end else begin
         if (cfg_we) nl_ff <= cfg_nl;
         if (cmd.feed_en) begin
            ps_ff   <= ps_in;
            n1_ff   <= n1_in;
            n2_ff   <= n2_in;
            crow_ff <= crow_in;
            ccol_ff <= ccol_in;
            top_ff  <= top_in;
            bg_ff   <= bg_in;
         end
         cnt_ff <= (cmd.sweep_fill || cmd.sweep_clear) && !status.sweep_done
                   ? cnt_ff + 1'b1 : '0;
      end
   end

   // input word and fill row latches
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff <= in_kind;
         char_ff <= in_char;
         rrow_ff <= in_row;
         rcol_ff <= in_col;
      end
      if (cmd.feed_en) fill_row_ff <= fill_row_in;
   end

   // one byte through the parser
   always_comb begin
      c       = cmd.feed_cr ? CH_CR : char_ff;
      c7      = c[6:0];
      digit   = (c >= CH_ZERO) && (c <= CH_NINE);
      ps_in   = ps_ff;
      n1_in   = n1_ff;
      n2_in   = n2_ff;
      crow_in = crow_ff;
      ccol_in = ccol_ff;
      top_in  = top_ff;
      bg_in   = bg_ff;
      lf      = 1'b0;
      mv      = 1'b0;
      fin     = 1'b0;
      fin_h   = 1'b0;
      fwr     = 1'b0;
      fill    = 1'b0;
      clr     = 1'b0;
      wcol    = ccol_ff;
      wdata   = c7;
      fill_row_in = top_ff;
      mc      = c;
      fr      = '0;
      fk      = '0;
      lrow    = '0;
      unique case (ps_ff)
         PS_IDLE: begin
            if (c == CH_ESC) begin
               ps_in = PS_ESC;
            end else if ({1'b0, c7} == CH_CR) begin
               ccol_in = '0;
            end else if ({1'b0, c7} == CH_BS || {1'b0, c7} == CH_DEL) begin
               if (ccol_ff != '0) begin
                  ccol_in = ccol_ff - 1'b1;
                  wcol    = ccol_ff - 1'b1;
                  wdata   = CH_SPACE[6:0];
                  fwr     = 1'b1;
               end
            end else if ({1'b0, c7} == CH_LF) begin
               lf = 1'b1;
            end else if ({1'b0, c7} >= CH_SPACE) begin
               fwr = 1'b1;
               if ({1'b0, c7} == CH_SPACE && bg_ff) wdata = CH_DEL[6:0];
               if (ccol_ff == COL_W'(COLUMNS - 1)) begin
                  ccol_in = '0;
                  lf      = 1'b1;
               end else begin
                  ccol_in = ccol_ff + 1'b1;
               end
            end
         end
         PS_ESC: begin
            ps_in = PS_IDLE;
            if (c == CH_LBR) ps_in = PS_ARG1;
            else if (c == CH_UY) ps_in = PS_YROW;
            else mv = 1'b1;
         end
         PS_ARG1: begin
            if (c == CH_SEMI) ps_in = PS_ARG2;
            else if (digit) n1_in = {n1_ff[4:0], 3'b0} + {n1_ff[6:0], 1'b0} + (c - CH_ZERO);
            else fin = 1'b1;
         end
         PS_ARG2: begin
            if (digit) n2_in = {n2_ff[4:0], 3'b0} + {n2_ff[6:0], 1'b0} + (c - CH_ZERO);
            else fin = 1'b1;
         end
         PS_YROW: begin
            n1_in = c - Y_BIAS;
            ps_in = PS_YCOL;
         end
         PS_YCOL: begin
            n2_in = c - Y_BIAS;
            fin   = 1'b1;
            fin_h = 1'b1;
         end
         PS_PRIV: begin
            if (!(digit || c == CH_SEMI)) ps_in = PS_IDLE;
         end
         default: ps_in = PS_IDLE;
      endcase

      // csi final byte
      if (fin) begin
         ps_in = PS_IDLE;
         if (fin_h || c == CH_UH) begin
            fr      = ((n1_in == '0) ? 8'd1 : n1_in) - 8'd1;
            fk      = ((n2_in == '0) ? 8'd1 : n2_in) - 8'd1;
            crow_in = mod_rows({1'b0, fr} + 9'(top_ff));
            ccol_in = (fk >= 8'(COLUMNS)) ? COL_W'(COLUMNS - 1) : fk[COL_W-1:0];
         end else if (c == CH_UJ) begin
            clr = 1'b1;
         end else if (c == CH_UA || c == CH_UB || c == CH_UC || c == CH_UD) begin
            mv = 1'b1;
         end else if (c == CH_LM) begin
            if (n1_in >= BG_LOW && n1_in <= BG_HIGH) bg_in = 1'b1;
            else if (n1_in == '0) bg_in = 1'b0;
         end else if (c == CH_QUEST) begin
            ps_in = PS_PRIV;
         end
         n1_in = '0;
         n2_in = '0;
      end

      // cursor moves
      if (mv) begin
         if (mc == CH_UA) crow_in = row_prev(crow_ff);
         else if (mc == CH_UB) crow_in = row_next(crow_ff);
         else if (mc == CH_UC) begin
            if (ccol_ff < COL_W'(COLUMNS - 1)) ccol_in = ccol_ff + 1'b1;
         end else if (mc == CH_UD) begin
            if (ccol_ff != '0) ccol_in = ccol_ff - 1'b1;
         end
      end

      // line feed with scroll
      if (lf) begin
         lrow    = row_next(crow_ff);
         crow_in = lrow;
         if (lrow == top_ff) begin
            fill   = 1'b1;
            top_in = row_next(top_ff);
         end
      end
   end

   // store port
   logic [ADDR_W-1:0] waddr, raddr;
   logic [6:0]        wd;
   logic              we;
   logic [ROW_W-1:0]  prow;

   always_comb begin
      we    = 1'b0;
      waddr = cell_addr(crow_ff, wcol);
      wd    = wdata;
      if (cmd.feed_en && fwr) begin
         we = 1'b1;
      end else if (cmd.sweep_fill) begin
         we    = 1'b1;
         waddr = cell_addr(fill_row_ff, cnt_ff[COL_W-1:0]);
         wd    = CH_SPACE[6:0];
      end else if (cmd.sweep_clear) begin
         we    = 1'b1;
         waddr = cnt_ff;
         wd    = CH_SPACE[6:0];
      end
      prow  = mod_rows(9'(top_ff) + 9'(rrow_ff));
      raddr = cell_addr(prow, (rcol_ff < 6'(COLUMNS)) ? rcol_ff : '0);
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wd;
      mem_q_ff <= mem[raddr];
   end

   // status and result
   always_comb begin
      status.need_fill   = fill;
      status.need_clear  = clr;
      status.second_pass = (char_ff == CH_LF) && nl_ff;
      status.sweep_done  = cmd.sweep_fill ? (cnt_ff == ADDR_W'(COLUMNS - 1))
                                          : (cnt_ff == ADDR_W'(CELLS - 1));
      status.is_read     = in_kind;
      cell_value = (kind_ff && rcol_ff < 6'(COLUMNS)) ? mem_q_ff : '0;
      cursor_row = crow_ff;
      cursor_col = ccol_ff;
      top_row    = top_ff;
      background = bg_ff;
   end

endmodule

// File: src/text_terminal_escape_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_escape_engine
// Character-cell terminal with a VT52 / ANSI subset parser over a circular
// 40x29 screen store; each command feeds one byte or reads one cell.
//
//   channel  ports                         handshake
//   req      start/busy, req_*             start && !busy
//   rsp      rsp_valid, rsp_*              one-cycle strobe
//   csr      csr_valid/csr_ready, csr_*    valid && ready
//
// A cell read passes through the read state and a plain byte through the feed
// state before its result strobes; a line feed with return takes a second feed
// pass. The next start is taken once the engine is back in idle. A scroll adds
// a row fill, a screen clear adds a sweep of every cell, both set by the
// single write port of the store. After reset a clearing pass over every cell runs with busy high.
// The receiver cannot stall; csr is always ready.
// ----------------------------------------------------------------------------
module text_terminal_escape_engine (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_kind,
   input  logic [7:0] req_char_code,
   input  logic [4:0] req_read_row,
   input  logic [5:0] req_read_col,
   output logic       rsp_valid,
   output logic [6:0] rsp_cell_value,
   output logic [4:0] rsp_cursor_row_out,
   output logic [5:0] rsp_cursor_col_out,
   output logic [4:0] rsp_top_row_out,
   output logic       rsp_background_on,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_newline_adds_return
);
   import tte_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;
   assign rsp_valid = cmd.rsp_valid;

   // sequencer
   tte_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // parser and store
   tte_datapath u_dp (
      .clock      (clock),
      .cmd        (cmd),
      .status     (status),
      .cfg_we     (csr_valid),
      .cfg_nl     (csr_newline_adds_return),
      .reset      (reset),
      .in_kind    (req_kind),
      .in_char    (req_char_code),
      .in_row     (req_read_row),
      .in_col     (req_read_col),
      .cell_value (rsp_cell_value),
      .cursor_row (rsp_cursor_row_out),
      .cursor_col (rsp_cursor_col_out),
      .top_row    (rsp_top_row_out),
      .background (rsp_background_on)
   );

endmodule
